FILE: rtl/core/fcpd_pkg.sv
// Shared types, constants and helper functions of the four-channel phase dimmer.
// Used by four_channel_phase_dimmer_top and its port checker; depends on nothing.
package fcpd_pkg;

   localparam int CHANNELS_DEFAULT = 4;
   localparam int MAX_CHANNELS     = 4;

   localparam int TIMER_W  = 16;
   localparam int LEVEL_W  = 16;
   localparam int SAMPLE_W = 8;
   localparam int BYTE_W   = 8;
   localparam int COUNT_W  = 8;
   localparam int CODE_W   = 6;
   localparam int CHSEL_W  = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic REQ_TICK   = 1'b0;
   localparam logic REQ_SERIAL = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_SLEW_STEP       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_HALF_PERIOD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_HALF_PERIOD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DARK_THRESHOLD  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BLINK_COUNT     = 3'd4;

   localparam logic [LEVEL_W-1:0]  SLEW_STEP_RESET       = 16'd50;
   localparam logic [TIMER_W-1:0]  MIN_HALF_PERIOD_RESET = 16'd6000;
   localparam logic [TIMER_W-1:0]  MAX_HALF_PERIOD_RESET = 16'd60000;
   localparam logic [SAMPLE_W-1:0] DARK_THRESHOLD_RESET  = 8'd50;
   localparam logic [COUNT_W-1:0]  BLINK_COUNT_RESET     = 8'd4;

   localparam logic [LEVEL_W-1:0]  LEVEL_RESET  = 16'd12000;
   localparam logic [LEVEL_W-1:0]  LEVEL_OFFSET = 16'd50;
   localparam int                  LEVEL_SHIFT  = 6;
   localparam logic [CODE_W-1:0]   CODE_NEVER   = 6'h3f;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX   = 8'hff;

   localparam logic [LEVEL_W-1:0] NEVER_FIRE_LEVEL =
      LEVEL_W'((LEVEL_W'(CODE_NEVER) + LEVEL_OFFSET) << LEVEL_SHIFT);

   typedef struct packed {
      logic                req_type;
      logic [SAMPLE_W-1:0] sensor_sample;
      logic [BYTE_W-1:0]   rx_byte;
      logic                rx_error;
   } req_item_type;

   function automatic logic [LEVEL_W-1:0] level_of_code(input logic [CODE_W-1:0] code);
      logic [LEVEL_W-1:0] level;
      if (code == '0) begin
         level = '0;
      end else begin
         level = LEVEL_W'((LEVEL_W'(code) + LEVEL_OFFSET) << LEVEL_SHIFT);
      end
      return level;
   endfunction

   function automatic logic [LEVEL_W-1:0] slew(input logic [LEVEL_W-1:0] cur,
                                              input logic [LEVEL_W-1:0] target,
                                              input logic [LEVEL_W-1:0] step);
      logic [LEVEL_W-1:0] result;
      if ((cur > target) && ((cur - target) > step)) begin
         result = cur - step;
      end else if ((cur < target) && ((target - cur) > step)) begin
         result = cur + step;
      end else begin
         result = target;
      end
      return result;
   endfunction

endpackage

FILE: rtl/core/four_channel_phase_dimmer_top.sv
// Four-channel phase-angle dimmer: input register, one pass of update logic, result register.
// Depends on fcpd_pkg.
//
// Usage:
//   req_* carries either a microsecond tick with a light sensor sample (req_type = tick)
//   or a received serial byte with its error flag (req_type = serial). An item transfers
//   at a clock edge with req_valid high and req_stall low.
//   rsp_* returns one result per item: gate levels, LED level and phase timer after the
//   item. A result transfers at an edge with rsp_valid high and rsp_stall low.
//   csr_* writes one of five registers; csr_ready is always high.
// Path: an item is registered in the input register, then its result in the state and result
//   registers; while a result is stalled, the next item waits in the input register.
// Throughput: one item per cycle unless a result is stalled; the whole per-item update is one
//   combinational pass over the timer compare, the four channel slew units and the gate compares.
// Reset: returns registers, timer, setpoints, delays, gates and LED to their defaults
//   and empties both stages.
// Stall: while rsp_stall holds a result, the result and state hold; one more item
//   waits in the input register, then req_stall rises until the result transfers.
module four_channel_phase_dimmer_top #(
   parameter int CHANNELS = fcpd_pkg::CHANNELS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_type,
   input  logic [fcpd_pkg::SAMPLE_W-1:0]     req_sensor_sample,
   input  logic [fcpd_pkg::BYTE_W-1:0]       req_rx_byte,
   input  logic                              req_rx_error,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [fcpd_pkg::MAX_CHANNELS-1:0] rsp_gate_drive,
   output logic                              rsp_led_on,
   output logic [fcpd_pkg::TIMER_W-1:0]      rsp_phase_time,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fcpd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fcpd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   fcpd_pkg::req_item_type item_ff;
   logic                   in_valid_ff;
   logic                   in_valid_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   advance;
   logic                   update;

   logic [fcpd_pkg::LEVEL_W-1:0]  slew_step_ff;
   logic [fcpd_pkg::TIMER_W-1:0]  min_half_period_ff;
   logic [fcpd_pkg::TIMER_W-1:0]  max_half_period_ff;
   logic [fcpd_pkg::SAMPLE_W-1:0] dark_threshold_ff;
   logic [fcpd_pkg::COUNT_W-1:0]  blink_count_ff;

   logic [fcpd_pkg::TIMER_W-1:0]      phase_timer_ff;
   logic [fcpd_pkg::TIMER_W-1:0]      phase_timer_in;
   logic [fcpd_pkg::LEVEL_W-1:0]      setpoint_ff [CHANNELS];
   logic [fcpd_pkg::LEVEL_W-1:0]      setpoint_in [CHANNELS];
   logic [fcpd_pkg::LEVEL_W-1:0]      delay_ff    [CHANNELS];
   logic [fcpd_pkg::LEVEL_W-1:0]      delay_in    [CHANNELS];
   logic [fcpd_pkg::MAX_CHANNELS-1:0] gate_latch_ff;
   logic [fcpd_pkg::MAX_CHANNELS-1:0] gate_latch_in;
   logic [fcpd_pkg::COUNT_W-1:0]      blink_counter_ff;
   logic [fcpd_pkg::COUNT_W-1:0]      blink_counter_in;
   logic                              led_level_ff;
   logic                              led_level_in;

   assign advance      = !rsp_valid_ff || !rsp_stall;
   assign update       = advance && in_valid_ff;
   assign req_stall    = in_valid_ff && !advance;
   assign in_valid_in  = (req_valid && !req_stall) || (in_valid_ff && !advance);
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;
   assign csr_ready    = 1'b1;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_gate_drive = gate_latch_ff;
   assign rsp_led_on     = led_level_ff;
   assign rsp_phase_time = phase_timer_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff.req_type      <= req_type;
         item_ff.sensor_sample <= req_sensor_sample;
         item_ff.rx_byte       <= req_rx_byte;
         item_ff.rx_error      <= req_rx_error;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slew_step_ff       <= fcpd_pkg::SLEW_STEP_RESET;
         min_half_period_ff <= fcpd_pkg::MIN_HALF_PERIOD_RESET;
         max_half_period_ff <= fcpd_pkg::MAX_HALF_PERIOD_RESET;
         dark_threshold_ff  <= fcpd_pkg::DARK_THRESHOLD_RESET;
         blink_count_ff     <= fcpd_pkg::BLINK_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            fcpd_pkg::CSR_SLEW_STEP: begin
               slew_step_ff <= csr_wdata;
            end
            fcpd_pkg::CSR_MIN_HALF_PERIOD: begin
               min_half_period_ff <= csr_wdata;
            end
            fcpd_pkg::CSR_MAX_HALF_PERIOD: begin
               max_half_period_ff <= csr_wdata;
            end
            fcpd_pkg::CSR_DARK_THRESHOLD: begin
               dark_threshold_ff <= csr_wdata[fcpd_pkg::SAMPLE_W-1:0];
            end
            fcpd_pkg::CSR_BLINK_COUNT: begin
               blink_count_ff <= csr_wdata[fcpd_pkg::COUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      logic [fcpd_pkg::TIMER_W-1:0]  timer_inc;
      logic [fcpd_pkg::SAMPLE_W-1:0] inv_sample;
      logic                          period_end;
      logic [fcpd_pkg::CHSEL_W-1:0]  chsel;
      timer_inc  = phase_timer_ff + 16'd1;
      inv_sample = fcpd_pkg::SAMPLE_MAX - item_ff.sensor_sample;
      period_end = ((timer_inc > min_half_period_ff) && (inv_sample < dark_threshold_ff)) ||
                   (timer_inc > max_half_period_ff);
      chsel      = item_ff.rx_byte[fcpd_pkg::BYTE_W-1 -: fcpd_pkg::CHSEL_W];

      phase_timer_in   = phase_timer_ff;
      gate_latch_in    = gate_latch_ff;
      blink_counter_in = blink_counter_ff;
      led_level_in     = led_level_ff;
      for (int i = 0; i < CHANNELS; i++) begin
         setpoint_in[i] = setpoint_ff[i];
         delay_in[i]    = delay_ff[i];
      end

      case (item_ff.req_type)
         fcpd_pkg::REQ_SERIAL: begin
            if (item_ff.rx_error) begin
               led_level_in = 1'b1;
            end else begin
               for (int i = 0; i < CHANNELS; i++) begin
                  if (chsel == fcpd_pkg::CHSEL_W'(i)) begin
                     setpoint_in[i] =
                        fcpd_pkg::level_of_code(item_ff.rx_byte[fcpd_pkg::CODE_W-1:0]);
                  end
               end
            end
         end
         fcpd_pkg::REQ_TICK: begin
            phase_timer_in = timer_inc;
            if (period_end) begin
               phase_timer_in   = '0;
               gate_latch_in    = '0;
               blink_counter_in = blink_counter_ff + 8'd1;
               led_level_in     = blink_counter_in < blink_count_ff;
               for (int i = 0; i < CHANNELS; i++) begin
                  delay_in[i] = fcpd_pkg::slew(delay_ff[i], setpoint_ff[i], slew_step_ff);
               end
            end
            for (int i = 0; i < CHANNELS; i++) begin
               if ((phase_timer_in >= delay_in[i]) &&
                   (setpoint_ff[i] != fcpd_pkg::NEVER_FIRE_LEVEL)) begin
                  gate_latch_in[i] = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_timer_ff   <= '0;
         gate_latch_ff    <= '0;
         blink_counter_ff <= '0;
         led_level_ff     <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            setpoint_ff[i] <= fcpd_pkg::LEVEL_RESET;
            delay_ff[i]    <= fcpd_pkg::LEVEL_RESET;
         end
      end else if (update) begin
         phase_timer_ff   <= phase_timer_in;
         gate_latch_ff    <= gate_latch_in;
         blink_counter_ff <= blink_counter_in;
         led_level_ff     <= led_level_in;
         for (int i = 0; i < CHANNELS; i++) begin
            setpoint_ff[i] <= setpoint_in[i];
            delay_ff[i]    <= delay_in[i];
         end
      end
   end

endmodule

FILE: rtl/core/fcpd_port_checker.sv
// Port-level checks of four_channel_phase_dimmer_top, bound to every instance.
// Depends on fcpd_pkg and four_channel_phase_dimmer_top.
module fcpd_port_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [fcpd_pkg::MAX_CHANNELS-1:0] rsp_gate_drive,
   input logic                              rsp_led_on,
   input logic [fcpd_pkg::TIMER_W-1:0]      rsp_phase_time
);

   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_gate_drive) &&
                                    $stable(rsp_led_on) && $stable(rsp_phase_time)))
      else $error("stalled result changed");

   a_no_stall_through: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while result side is free");

   a_gate_drop_at_start: assert property (@(posedge clock) disable iff (reset)
      ((($past(rsp_gate_drive) & ~rsp_gate_drive) != '0) |-> (rsp_phase_time == '0)))
      else $error("gate dropped away from a half-period start");

endmodule

bind four_channel_phase_dimmer_top fcpd_port_checker u_fcpd_port_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_gate_drive (rsp_gate_drive),
   .rsp_led_on     (rsp_led_on),
   .rsp_phase_time (rsp_phase_time)
);
